>>> rtl/assert_macros.svh
// assertion helpers used by process_tick_timer_with_heater_pwm
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the process tick timer modules.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// item kind codes
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] REG_CYCLE_TIME_LIMIT = 2'd1;
	localparam logic [1:0] REG_FILL_TIME_LIMIT  = 2'd2;
	localparam logic [1:0] REG_START_HOLD_LIMIT = 2'd3;

	// configuration reset values
	localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd200;
	localparam logic [15:0] CYCLE_TIME_LIMIT_RST = 16'd5400;
	localparam logic [15:0] FILL_TIME_LIMIT_RST  = 16'd600;
	localparam logic [7:0]  START_HOLD_LIMIT_RST = 8'd3;

	// countdown limits
	localparam logic [6:0] MIN_CAP    = 7'd99;
	localparam logic [5:0] SEC_RELOAD = 6'd59;

	typedef struct packed {
		logic [15:0] ticks_per_second;
		logic [15:0] cycle_time_limit;
		logic [15:0] fill_time_limit;
		logic [7:0]  start_hold_limit;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  load_ster_minutes;
		logic [6:0]  load_dry_minutes;
		logic [15:0] heater_on_ticks;
		logic [15:0] heater_period_ticks;
		logic        heating_enabled;
		logic        sterilizing;
		logic        exhausting;
		logic        drying;
		logic        cycle_running;
		logic        fill_pending;
		logic        start_held;
	} item_t;

	typedef struct packed {
		logic        heater_drive;
		logic        second_strobe;
		logic [6:0]  ster_minutes;
		logic [5:0]  ster_seconds;
		logic [6:0]  dry_minutes;
		logic [5:0]  dry_seconds;
		logic [15:0] cycle_seconds;
		logic [15:0] fill_seconds;
		logic [7:0]  start_hold_seconds;
		logic        long_cycle_alarm;
		logic        fill_timeout_alarm;
		logic        emergency_alarm;
	} result_t;

endpackage

>>> rtl/process_tick_timer_with_heater_pwm.sv
// ----------------------------------------------------------------------------
// process_tick_timer_with_heater_pwm
// Item channel (item_valid / item_stall): one 5 ms tick or a minutes load
// per transfer. Result channel (result_valid / result_stall): one result per
// item, in order. Configuration: cfg_write with cfg_index and cfg_data sets
// the second prescale and the alarm limits; write only while idle.
// An item passes through an input register, then the state update and the
// result register in one pass. The block takes one item per cycle while
// result_stall is low.
// A stalled result holds; the input register keeps taking one more item and
// item_stall rises only once both registers are full. Reset clears the
// timer state, the emergency latch and both valid flags and restores the
// default limits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module process_tick_timer_with_heater_pwm (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [6:0]  load_ster_minutes,
	input  logic [6:0]  load_dry_minutes,
	input  logic [15:0] heater_on_ticks,
	input  logic [15:0] heater_period_ticks,
	input  logic        heating_enabled,
	input  logic        sterilizing,
	input  logic        exhausting,
	input  logic        drying,
	input  logic        cycle_running,
	input  logic        fill_pending,
	input  logic        start_held,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        heater_drive,
	output logic        second_strobe,
	output logic [6:0]  ster_minutes,
	output logic [5:0]  ster_seconds,
	output logic [6:0]  dry_minutes,
	output logic [5:0]  dry_seconds,
	output logic [15:0] cycle_seconds,
	output logic [15:0] fill_seconds,
	output logic [7:0]  start_hold_seconds,
	output logic        long_cycle_alarm,
	output logic        fill_timeout_alarm,
	output logic        emergency_alarm
);

	ptt_pkg::cfg_t    cfg;
	ptt_pkg::item_t   item_in, item_s1;
	ptt_pkg::result_t res_next, res_q;
	logic             valid_s1, res_valid_q, advance;

	ptt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// gather the item fields
	always_comb begin
		item_in.kind                = kind;
		item_in.load_ster_minutes   = load_ster_minutes;
		item_in.load_dry_minutes    = load_dry_minutes;
		item_in.heater_on_ticks     = heater_on_ticks;
		item_in.heater_period_ticks = heater_period_ticks;
		item_in.heating_enabled     = heating_enabled;
		item_in.sterilizing         = sterilizing;
		item_in.exhausting          = exhausting;
		item_in.drying              = drying;
		item_in.cycle_running       = cycle_running;
		item_in.fill_pending        = fill_pending;
		item_in.start_held          = start_held;
	end

	// handshake: the item moves on when the result register is free or draining
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_in;
		end
	end

	ptt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	// result fields
	assign result_valid       = res_valid_q;
	assign heater_drive       = res_q.heater_drive;
	assign second_strobe      = res_q.second_strobe;
	assign ster_minutes       = res_q.ster_minutes;
	assign ster_seconds       = res_q.ster_seconds;
	assign dry_minutes        = res_q.dry_minutes;
	assign dry_seconds        = res_q.dry_seconds;
	assign cycle_seconds      = res_q.cycle_seconds;
	assign fill_seconds       = res_q.fill_seconds;
	assign start_hold_seconds = res_q.start_hold_seconds;
	assign long_cycle_alarm   = res_q.long_cycle_alarm;
	assign fill_timeout_alarm = res_q.fill_timeout_alarm;
	assign emergency_alarm    = res_q.emergency_alarm;

	// checks
	`ASSERT_IMPLY(a_stall_needs_full, clk, arst_n, item_stall, valid_s1 && res_valid_q)
	`ASSERT_NEXT(a_load_no_strobe, clk, arst_n, advance && item_s1.kind == ptt_pkg::KIND_LOAD, !res_q.second_strobe)
	`ASSERT_NEXT(a_emergency_sticky, clk, arst_n, advance && res_valid_q && res_q.emergency_alarm, res_q.emergency_alarm)
	`ASSERT_IMPLY(a_seconds_range, clk, arst_n, res_valid_q, res_q.ster_seconds <= ptt_pkg::SEC_RELOAD && res_q.dry_seconds <= ptt_pkg::SEC_RELOAD)

endmodule

>>> rtl/ptt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptt_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ptt_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_write,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output ptt_pkg::cfg_t  cfg
);

	ptt_pkg::cfg_t cfg_q;

	// register write, reset to the power-up limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= ptt_pkg::TICKS_PER_SECOND_RST;
			cfg_q.cycle_time_limit <= ptt_pkg::CYCLE_TIME_LIMIT_RST;
			cfg_q.fill_time_limit  <= ptt_pkg::FILL_TIME_LIMIT_RST;
			cfg_q.start_hold_limit <= ptt_pkg::START_HOLD_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ptt_pkg::REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data;
				ptt_pkg::REG_CYCLE_TIME_LIMIT: cfg_q.cycle_time_limit <= cfg_data;
				ptt_pkg::REG_FILL_TIME_LIMIT:  cfg_q.fill_time_limit  <= cfg_data;
				ptt_pkg::REG_START_HOLD_LIMIT: cfg_q.start_hold_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/ptt_core.sv
// ----------------------------------------------------------------------------
// ptt_core
// Timer state and its single-pass update: heater phase, second prescaler,
// countdowns, elapsed counters, alarms and the emergency latch.
// ----------------------------------------------------------------------------
module ptt_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  ptt_pkg::item_t    item,
	input  ptt_pkg::cfg_t     cfg,
	output ptt_pkg::result_t  res
);

	logic [15:0] prescale_q, prescale_n, prescale_inc;
	logic [15:0] phase_q, phase_n, phase_inc;
	logic        level_q, level_n;
	logic [6:0]  ster_min_q, ster_min_n, dry_min_q, dry_min_n;
	logic [5:0]  ster_sec_q, ster_sec_n, dry_sec_q, dry_sec_n;
	logic [15:0] cycle_q, cycle_n, fill_q, fill_n;
	logic [7:0]  start_q, start_n;
	logic        latch_q, latch_n;
	logic        strobe;
	logic [12:0] ster_dec, dry_dec;

	// mm:ss countdown that stops at zero
	function automatic logic [12:0] count_down(input logic [6:0] mins,
		input logic [5:0] secs);
		logic [6:0] m;
		logic [5:0] s;
		m = mins;
		s = secs;
		if (secs != 6'd0) begin
			s = secs - 6'd1;
		end else if (mins != 7'd0) begin
			m = mins - 7'd1;
			s = ptt_pkg::SEC_RELOAD;
		end
		return {m, s};
	endfunction

	assign prescale_inc = prescale_q + 16'd1;
	assign phase_inc    = phase_q + 16'd1;
	assign ster_dec     = count_down(ster_min_q, ster_sec_q);
	assign dry_dec      = count_down(dry_min_q, dry_sec_q);

	// next state for one item
	always_comb begin
		prescale_n = prescale_q;
		phase_n    = phase_q;
		level_n    = level_q;
		ster_min_n = ster_min_q;
		ster_sec_n = ster_sec_q;
		dry_min_n  = dry_min_q;
		dry_sec_n  = dry_sec_q;
		cycle_n    = cycle_q;
		fill_n     = fill_q;
		start_n    = start_q;
		strobe     = 1'b0;
		if (item.kind == ptt_pkg::KIND_LOAD) begin
			ster_min_n = (item.load_ster_minutes > ptt_pkg::MIN_CAP) ?
				ptt_pkg::MIN_CAP : item.load_ster_minutes;
			dry_min_n  = (item.load_dry_minutes > ptt_pkg::MIN_CAP) ?
				ptt_pkg::MIN_CAP : item.load_dry_minutes;
			ster_sec_n = 6'd0;
			dry_sec_n  = 6'd0;
		end else begin
			prescale_n = prescale_inc;
			phase_n    = phase_inc;
			// heater pwm, drive holds while disabled
			if (item.heating_enabled) begin
				level_n = (phase_inc < item.heater_on_ticks);
				if (phase_inc >= item.heater_period_ticks) begin
					phase_n = 16'd0;
				end
			end
			// second strobe work
			if (prescale_inc >= cfg.ticks_per_second) begin
				strobe     = 1'b1;
				prescale_n = 16'd0;
				if (item.cycle_running && !item.sterilizing && cycle_q != 16'hFFFF) begin
					cycle_n = cycle_q + 16'd1;
				end
				if (item.start_held && start_q != 8'hFF) begin
					start_n = start_q + 8'd1;
				end
				if (item.fill_pending && fill_q != 16'hFFFF) begin
					fill_n = fill_q + 16'd1;
				end
				if (item.sterilizing && !item.exhausting) begin
					{ster_min_n, ster_sec_n} = ster_dec;
				end
				if (item.drying) begin
					{dry_min_n, dry_sec_n} = dry_dec;
				end
			end
		end
		// level-driven clears
		if (item.sterilizing) begin
			cycle_n = 16'd0;
		end
		if (!item.start_held) begin
			start_n = 8'd0;
		end
		latch_n = latch_q | (start_n > cfg.start_hold_limit);
	end

	// result from the updated state
	always_comb begin
		res.heater_drive       = level_n;
		res.second_strobe      = strobe;
		res.ster_minutes       = ster_min_n;
		res.ster_seconds       = ster_sec_n;
		res.dry_minutes        = dry_min_n;
		res.dry_seconds        = dry_sec_n;
		res.cycle_seconds      = cycle_n;
		res.fill_seconds       = fill_n;
		res.start_hold_seconds = start_n;
		res.long_cycle_alarm   = (cycle_n > cfg.cycle_time_limit);
		res.fill_timeout_alarm = (fill_n > cfg.fill_time_limit);
		res.emergency_alarm    = latch_n;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= 16'd0;
			phase_q    <= 16'd0;
			level_q    <= 1'b0;
			ster_min_q <= 7'd0;
			ster_sec_q <= 6'd0;
			dry_min_q  <= 7'd0;
			dry_sec_q  <= 6'd0;
			cycle_q    <= 16'd0;
			fill_q     <= 16'd0;
			start_q    <= 8'd0;
			latch_q    <= 1'b0;
		end else if (update) begin
			prescale_q <= prescale_n;
			phase_q    <= phase_n;
			level_q    <= level_n;
			ster_min_q <= ster_min_n;
			ster_sec_q <= ster_sec_n;
			dry_min_q  <= dry_min_n;
			dry_sec_q  <= dry_sec_n;
			cycle_q    <= cycle_n;
			fill_q     <= fill_n;
			start_q    <= start_n;
			latch_q    <= latch_n;
		end
	end

endmodule
